// ----- sv/sut_pkg.sv -----
// Shared types and constants of the sparse unit triangular solve core.
`default_nettype none

package sut_pkg;

  localparam int unsigned IDX_W       = 12;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned PROD_W      = 2 * VAL_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_APPLY = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_MUL,
    BK_WB,
    BK_RDONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        column_index;
    logic signed [VAL_W-1:0] operand_value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    saturated_seen;
  } out_t;

  typedef struct packed {
    logic transpose_mode;
  } cfg_t;

  // Classified command: tgt is the element written (or read), src the one scaled.
  typedef struct packed {
    op_e                     op;
    logic                    in_range;
    logic [IDX_W-1:0]        tgt_idx;
    logic [IDX_W-1:0]        src_idx;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/sut_chan_if.sv -----
// Valid/ready channel interface with a typed payload.
`default_nettype none

interface sut_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/sparse_unit_triangular_solve_core.sv -----
// Top level of the sparse unit triangular solve core.
`default_nettype none

// Holds a VECTOR_DEPTH-entry Q16.16 solution vector in on-chip memory. Software
// loads the right-hand side, streams off-diagonal entries of a unit lower
// triangular factor (apply: y[col] -= v*y[row] forward, y[row] -= v*y[col]
// transposed, rows ascending forward and descending transposed), then reads
// elements back; only read transactions produce a result. The front end takes
// one input transaction per cycle, while the two-entry command queue has room;
// the back end runs one command at a time: load and clear pop and execute; read
// also waits out any output stall; apply pops, reads both elements, does a
// 32x32 multiply and a saturating write-back. Sustained throughput is set by
// the back end's read-multiply-write sequence on the single-write-port memory.
// Memory contents are undefined after reset; no clearing pass is run.
// transpose_mode may only be changed while the core is idle.
module sparse_unit_triangular_solve_core #(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sut_chan_if.sink    cfg_i,
  sut_chan_if.sink    in_i,
  sut_chan_if.source  out_o
);

  logic transpose_q;

  sut_chan_if #(.payload_t(sut_pkg::cmd_t)) front_q_if ();
  sut_chan_if #(.payload_t(sut_pkg::cmd_t)) q_back_if ();

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= 1'b0;
    end else if (cfg_i.valid) begin
      transpose_q <= cfg_i.payload.transpose_mode;
    end
  end

  sut_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .transpose_i (transpose_q),
    .in_i        (in_i),
    .cmd_o       (front_q_if)
  );

  sut_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_q_if),
    .pop_o  (q_back_if)
  );

  sut_back #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_back_if),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ----- sv/sut_front.sv -----
// Front end: accepts input transactions, range-checks and resolves operand roles.
`default_nettype none

module sut_front #(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   transpose_i,
  sut_chan_if.sink    in_i,
  sut_chan_if.source  cmd_o
);

  logic            valid_q;
  sut_pkg::cmd_t   cmd_q;
  sut_pkg::cmd_t   cmd_d;
  sut_pkg::op_e    op;
  logic            r_ok;
  logic            c_ok;
  logic            accept;

  assign in_i.ready = !valid_q || cmd_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign op   = sut_pkg::op_e'(in_i.payload.opcode);
  assign r_ok = 32'(in_i.payload.row_index) < VECTOR_DEPTH;
  assign c_ok = 32'(in_i.payload.column_index) < VECTOR_DEPTH;

  always_comb begin
    cmd_d.op      = op;
    cmd_d.value   = in_i.payload.operand_value;
    cmd_d.tgt_idx = in_i.payload.row_index;
    cmd_d.src_idx = in_i.payload.column_index;
    case (op)
      sut_pkg::OP_APPLY: begin
        cmd_d.in_range = r_ok && c_ok;
        // forward: column element is updated from the row element
        if (!transpose_i) begin
          cmd_d.tgt_idx = in_i.payload.column_index;
          cmd_d.src_idx = in_i.payload.row_index;
        end
      end
      default: begin
        cmd_d.in_range = r_ok;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o.valid   = valid_q;
  assign cmd_o.payload = cmd_q;

endmodule

`default_nettype wire

// ----- sv/sut_queue.sv -----
// Short command queue decoupling the front end from the execution back end.
`default_nettype none

module sut_queue (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sut_chan_if.sink    push_i,
  sut_chan_if.source  pop_o
);

  sut_pkg::cmd_t                 entry_q [sut_pkg::QUEUE_DEPTH];
  logic [sut_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [sut_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [sut_pkg::QCNT_W-1:0]    cnt_q;
  logic [sut_pkg::QCNT_W-1:0]    cnt_d;
  logic                          push;
  logic                          pop;

  assign push_i.ready  = cnt_q != sut_pkg::QCNT_W'(sut_pkg::QUEUE_DEPTH);
  assign pop_o.valid   = cnt_q != '0;
  assign pop_o.payload = entry_q[rd_ptr_q];

  assign push = push_i.valid && push_i.ready;
  assign pop  = pop_o.valid && pop_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == sut_pkg::QPTR_W'(sut_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == sut_pkg::QPTR_W'(sut_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i.payload;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sut_back.sv -----
// Back end: solution memory, multiply-subtract datapath and result register.
`default_nettype none

module sut_back #(
  parameter int unsigned VECTOR_DEPTH = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sut_chan_if.sink    cmd_i,
  sut_chan_if.source  out_o
);

  localparam int unsigned AW = $clog2(VECTOR_DEPTH);
  localparam logic signed [sut_pkg::PROD_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [sut_pkg::PROD_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  logic signed [sut_pkg::VAL_W-1:0] sol_mem [VECTOR_DEPTH];

  sut_pkg::back_state_e              state_q;
  sut_pkg::back_state_e              state_d;
  sut_pkg::cmd_t                     cmd_q;
  logic signed [sut_pkg::VAL_W-1:0]  tgt_rd_q;
  logic signed [sut_pkg::VAL_W-1:0]  src_rd_q;
  logic signed [sut_pkg::PROD_W-1:0] prod_q;
  logic                              flag_q;
  logic                              out_valid_q;
  sut_pkg::out_t                     out_q;

  logic                              out_free;
  logic                              pop;
  logic                              rd_en;
  logic                              mem_we;
  logic                              wb_sel;
  logic                              flag_set;
  logic                              flag_clr;
  logic                              out_load;
  logic [AW-1:0]                     tgt_addr;
  logic [AW-1:0]                     src_addr;
  logic signed [sut_pkg::PROD_W-1:0] prod_sh;
  logic signed [sut_pkg::PROD_W-1:0] diff;
  logic signed [sut_pkg::VAL_W-1:0]  sat_val;
  logic                              sat_hit;
  logic signed [sut_pkg::VAL_W-1:0]  wdata;

  assign out_free = !out_valid_q || out_o.ready;
  assign tgt_addr = AW'(cmd_q.tgt_idx);
  assign src_addr = AW'(cmd_q.src_idx);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sut_pkg::BK_IDLE: begin
        if (cmd_i.valid) state_d = sut_pkg::BK_EXEC;
      end
      sut_pkg::BK_EXEC: begin
        case (cmd_q.op)
          sut_pkg::OP_APPLY: begin
            state_d = cmd_q.in_range ? sut_pkg::BK_MUL : sut_pkg::BK_IDLE;
          end
          sut_pkg::OP_READ: begin
            if (out_free) state_d = sut_pkg::BK_RDONE;
          end
          default: begin
            state_d = sut_pkg::BK_IDLE;
          end
        endcase
      end
      sut_pkg::BK_MUL:   state_d = sut_pkg::BK_WB;
      sut_pkg::BK_WB:    state_d = sut_pkg::BK_IDLE;
      sut_pkg::BK_RDONE: state_d = sut_pkg::BK_IDLE;
      default:           state_d = sut_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    mem_we   = 1'b0;
    wb_sel   = 1'b0;
    flag_set = 1'b0;
    flag_clr = 1'b0;
    out_load = 1'b0;
    case (state_q)
      sut_pkg::BK_IDLE: begin
        pop = cmd_i.valid;
      end
      sut_pkg::BK_EXEC: begin
        case (cmd_q.op)
          sut_pkg::OP_LOAD:  mem_we   = cmd_q.in_range;
          sut_pkg::OP_APPLY: rd_en    = cmd_q.in_range;
          sut_pkg::OP_READ:  rd_en    = out_free;
          sut_pkg::OP_CLEAR: flag_clr = 1'b1;
          default: ;
        endcase
      end
      sut_pkg::BK_WB: begin
        mem_we   = 1'b1;
        wb_sel   = 1'b1;
        flag_set = sat_hit;
      end
      sut_pkg::BK_RDONE: begin
        out_load = 1'b1;
      end
      default: ;
    endcase
  end

  assign cmd_i.ready = state_q == sut_pkg::BK_IDLE;

  // floor of the Q16.16 product, then saturating subtract
  assign prod_sh = prod_q >>> sut_pkg::FRAC_W;
  assign diff    = sut_pkg::PROD_W'(tgt_rd_q) - prod_sh;
  always_comb begin
    sat_hit = 1'b1;
    if (diff > SAT_HI) begin
      sat_val = SAT_HI[sut_pkg::VAL_W-1:0];
    end else if (diff < SAT_LO) begin
      sat_val = SAT_LO[sut_pkg::VAL_W-1:0];
    end else begin
      sat_val = diff[sut_pkg::VAL_W-1:0];
      sat_hit = 1'b0;
    end
  end

  assign wdata = wb_sel ? sat_val : cmd_q.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sut_pkg::BK_IDLE;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (flag_clr) begin
        flag_q <= 1'b0;
      end else if (flag_set) begin
        flag_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i.payload;
    end
    if (state_q == sut_pkg::BK_MUL) begin
      prod_q <= sut_pkg::PROD_W'(cmd_q.value) * sut_pkg::PROD_W'(src_rd_q);
    end
    if (out_load) begin
      out_q.read_value     <= cmd_q.in_range ? tgt_rd_q : '0;
      out_q.saturated_seen <= flag_q;
    end
  end

  // solution memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sol_mem[tgt_addr] <= wdata;
    end
    if (rd_en) begin
      tgt_rd_q <= sol_mem[tgt_addr];
      src_rd_q <= sol_mem[src_addr];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_no_result_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_load |-> !out_valid_q)
    else $error("result register loaded while still holding a result");

  a_write_state: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == sut_pkg::BK_EXEC || state_q == sut_pkg::BK_WB))
    else $error("memory written outside execute or write-back");

  a_mul_then_wb: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    state_q == sut_pkg::BK_MUL |=> state_q == sut_pkg::BK_WB)
    else $error("multiply not followed by write-back");

  a_pop_exec: assert property (
    @(posedge clk_i) disable iff (!rst_ni) pop |=> state_q == sut_pkg::BK_EXEC)
    else $error("popped command not executed");

endmodule

`default_nettype wire
